// File: hdl/ttiba_pkg.sv
// Shared types, character codes and the digit decoder for the text-to-integer
// parser with base autodetect. No dependencies; imported by every other file.
`default_nettype none

package ttiba_pkg;

    // Field widths
    localparam int CHAR_W  = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int BASE_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_ONE   = 16'h0031;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_UA    = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UF    = 16'h0046;
    localparam logic [CHAR_W-1:0] CH_UX    = 16'h0058;
    localparam logic [CHAR_W-1:0] CH_LA    = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LB    = 16'h0062;
    localparam logic [CHAR_W-1:0] CH_LF    = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_LX    = 16'h0078;

    // Letter digits: low nibble of 'a'/'A' is 1, so +9 gives 10
    localparam logic [3:0] LETTER_OFS = 4'd9;

    // Parser phase
    typedef enum logic [1:0] {
        PH_START  = 2'd0,   // expecting sign or first character
        PH_SIGNED = 2'd1,   // sign seen, expecting first character
        PH_ZERO   = 2'd2,   // leading zero seen, prefix letter may follow
        PH_DIGITS = 2'd3    // accumulating digits
    } t_phase;

    // Detected base, as reported on base_code
    typedef enum logic [BASE_W-1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_BIN = 2'd2
    } t_base;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        chars_used;
        logic [BASE_W-1:0]         base_code;
    } t_result;

    // Digit value of a character in the given base
    function automatic t_digit digit_of(input logic [CHAR_W-1:0] c, input t_base sel);
        t_digit d;
        d.ok  = 1'b0;
        d.val = '0;
        case (sel)
            BASE_BIN: begin
                if (c == CH_ZERO || c == CH_ONE) begin
                    d.ok  = 1'b1;
                    d.val = c[3:0];
                end
            end
            BASE_HEX: begin
                if (c inside {[CH_ZERO:CH_NINE]}) begin
                    d.ok  = 1'b1;
                    d.val = c[3:0];
                end else if (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
                    d.ok  = 1'b1;
                    d.val = c[3:0] + LETTER_OFS;
                end
            end
            default: begin
                if (c inside {[CH_ZERO:CH_NINE]}) begin
                    d.ok  = 1'b1;
                    d.val = c[3:0];
                end
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ttiba_char_if.sv
// Character stream channel: valid/ready handshake with one 16-bit code.
// Depends on ttiba_pkg.
`default_nettype none

interface ttiba_char_if import ttiba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

// File: hdl/ttiba_res_if.sv
// Result channel: valid/ready handshake carrying value, count and base code.
// Depends on ttiba_pkg.
`default_nettype none

interface ttiba_res_if import ttiba_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        chars_used;
    logic [BASE_W-1:0]         base_code;

    modport source (output valid, output value, output chars_used, output base_code,
                    input ready);
    modport sink   (input valid, input value, input chars_used, input base_code,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/text_to_int_base_autodetect_top.sv
// Top level of the streaming integer parser with base autodetect.
// Depends on ttiba_pkg, ttiba_char_if, ttiba_res_if and the ttiba_* stages.
//
// One character per clock is accepted on i_char; each non-digit (NUL included)
// ends the current number and produces one transaction on o_res with the value
// (negated if a leading '-' was seen, wrapped to 32 bits), the characters used
// (saturating at 65535, terminator excluded) and the base (0 dec, 1 hex, 2 bin;
// prefixes "0x", "0X", "0b"). Throughput is one character per cycle; a result
// is loaded into the result register when the parser takes its terminator
// from the input register. The input only stalls when a terminator reaches
// the parser while the single result register still holds an untaken result.
`default_nettype none

module text_to_int_base_autodetect_top import ttiba_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttiba_char_if.sink  i_char,
    ttiba_res_if.source o_res
);

    logic              w_in_vld;
    logic [CHAR_W-1:0] w_in_char;
    logic              w_take;
    logic              w_load;
    logic              w_out_free;
    t_result           w_res;

    ttiba_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_take  (w_take),
        .o_vld   (w_in_vld),
        .o_char  (w_in_char)
    );

    ttiba_parser u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_in_vld),
        .i_char     (w_in_char),
        .i_res_free (w_out_free),
        .o_take     (w_take),
        .o_load     (w_load),
        .o_res      (w_res)
    );

    ttiba_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );

    // A result is only loaded into a register that is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!o_res.valid || o_res.ready))
        else $error("result loaded over an untaken result");

    // A stalled character stays in the input register unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_vld && !w_take) |=> (w_in_vld && $stable(w_in_char)))
        else $error("held character lost or changed");

    // An empty input register always takes a new character
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_vld |-> i_char.ready)
        else $error("input stalled with empty input register");

    // A load is always a take of the terminating character
    a_load_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_take)
        else $error("result loaded without consuming its terminator");

endmodule

`default_nettype wire

// File: hdl/ttiba_in_stage.sv
// Input register: captures one character per transaction for the parser.
// Depends on ttiba_pkg and ttiba_char_if.
`default_nettype none

module ttiba_in_stage import ttiba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ttiba_char_if.sink       i_char,
    input  wire logic        i_take,
    output logic             o_vld,
    output logic [CHAR_W-1:0] o_char
);

    logic              r_vld;
    logic [CHAR_W-1:0] r_char;

    // Room when empty or when the parser drains the held character
    assign i_char.ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.character;
        end
    end

    assign o_vld  = r_vld;
    assign o_char = r_char;

endmodule

`default_nettype wire

// File: hdl/ttiba_parser.sv
// Parse state and combinational step logic: sign, prefix, digit accumulate,
// terminate. Depends on ttiba_pkg.
`default_nettype none

module ttiba_parser import ttiba_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_res_free,
    output logic                   o_take,
    output logic                   o_load,
    output t_result                o_res
);

    t_phase              r_phase, n_phase;
    logic                r_neg, n_neg;
    t_base               r_base, n_base;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic               w_minus, w_lead, w_lead_zero, w_prefix_x, w_prefix_b;
    logic               w_special, w_term;
    t_digit             w_dig;
    logic [VALUE_W-1:0] w_scaled;
    logic [COUNT_W-1:0] w_count_inc;

    // Character classification against the current phase
    assign w_minus     = (r_phase == PH_START) && (i_char == CH_MINUS);
    assign w_lead      = ((r_phase == PH_START) && !w_minus) || (r_phase == PH_SIGNED);
    assign w_lead_zero = w_lead && (i_char == CH_ZERO);
    assign w_prefix_x  = (r_phase == PH_ZERO) && (i_char == CH_UX || i_char == CH_LX);
    assign w_prefix_b  = (r_phase == PH_ZERO) && (i_char == CH_LB);
    assign w_dig       = digit_of(i_char, r_base);
    assign w_special   = w_minus || w_lead_zero || w_prefix_x || w_prefix_b;
    assign w_term      = !w_special && !w_dig.ok;

    // Terminator waits while the result register is full
    assign o_take = i_vld && (!w_term || i_res_free);
    assign o_load = i_vld && w_term && i_res_free;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (o_take) begin
            if (w_term) begin
                n_phase = PH_START;
            end else if (w_minus) begin
                n_phase = PH_SIGNED;
            end else if (w_lead_zero) begin
                n_phase = PH_ZERO;
            end else begin
                n_phase = PH_DIGITS;
            end
        end
    end

    // acc * base as shifts, with one add for decimal
    always_comb begin
        case (r_base)
            BASE_HEX: w_scaled = r_acc << 4;
            BASE_BIN: w_scaled = r_acc << 1;
            default:  w_scaled = (r_acc << 3) + (r_acc << 1);
        endcase
    end

    assign w_count_inc = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;

    // Datapath state and result
    always_comb begin
        n_neg   = r_neg;
        n_base  = r_base;
        n_acc   = r_acc;
        n_count = r_count;
        if (o_take) begin
            if (w_term) begin
                n_neg   = 1'b0;
                n_base  = BASE_DEC;
                n_acc   = '0;
                n_count = '0;
            end else begin
                n_count = w_count_inc;
                if (w_minus) begin
                    n_neg = 1'b1;
                end else if (w_prefix_x) begin
                    n_base = BASE_HEX;
                end else if (w_prefix_b) begin
                    n_base = BASE_BIN;
                end else if (!w_lead_zero) begin
                    n_acc = w_scaled + {{(VALUE_W-4){1'b0}}, w_dig.val};
                end
            end
        end
        o_res.value      = $signed(r_neg ? (~r_acc + 1'b1) : r_acc);
        o_res.chars_used = r_count;
        o_res.base_code  = r_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_base  <= BASE_DEC;
            r_acc   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ttiba_out_stage.sv
// Result register: holds one finished number until the sink takes it.
// Depends on ttiba_pkg and ttiba_res_if.
`default_nettype none

module ttiba_out_stage import ttiba_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  t_result   i_res,
    output logic      o_free,
    ttiba_res_if.source o_res
);

    logic    r_vld;
    t_result r_res;

    // Free when empty or drained this cycle
    assign o_free = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid      = r_vld;
    assign o_res.value      = r_res.value;
    assign o_res.chars_used = r_res.chars_used;
    assign o_res.base_code  = r_res.base_code;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench for text_to_int_base_autodetect_top: a table of directed character
// streams, then random numbers, checked against a parser predictor or a table result.
// Depends on ttiba_pkg, ttiba_char_if, ttiba_res_if and the block's RTL.
`default_nettype none

module testbench;
    import ttiba_pkg::*;

    // Characters used by the stimulus only
    localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
    localparam logic [CHAR_W-1:0] CH_TWO   = 16'h0032;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 16'h0037;
    localparam logic [CHAR_W-1:0] CH_UG    = 16'h0047;
    localparam logic [CHAR_W-1:0] CH_LG    = 16'h0067;
    localparam logic [CHAR_W-1:0] CH_TOP   = 16'hFFFF;
    // Non-digits sitting right next to the digit ranges
    localparam logic [CHAR_W-1:0] NEAR_DIGITS [6] = '{16'h002F, 16'h003A, 16'h0040,
                                                      16'h0047, 16'h0060, 16'h0067};

    localparam int RANDOM_ITEMS = 540;
    localparam int CALM_ITEMS   = 100;    // no idling over the last stretch
    localparam int LONG_RUN     = 40;     // decimal digits, far past the 32-bit wrap

    typedef struct {
        logic [CHAR_W-1:0] ch;
        int unsigned       reps;
        bit                typed;
        t_result           res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    ttiba_char_if char_if ();
    ttiba_res_if  res_if ();

    text_to_int_base_autodetect_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_res   (res_if)
    );

    // Parser predictor state
    t_phase            pr_phase;
    logic              pr_negative;
    t_base             pr_base;
    logic [31:0]       pr_acc;
    logic [COUNT_W-1:0] pr_count;

    t_stim_row  stim_table[$];
    t_result    pending_numbers[$];
    bit         row_typed;
    t_result    row_res;
    bit         calm;
    int         stall_left;
    int         chars_sent;
    int         numbers_checked;
    int         fault_count;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor helpers
    function automatic void clear_parser();
        pr_phase    = PH_START;
        pr_negative = 1'b0;
        pr_base     = BASE_DEC;
        pr_acc      = '0;
        pr_count    = '0;
    endfunction

    function automatic void count_char();
        if (pr_count != COUNT_MAX)
            pr_count = pr_count + 1'b1;
    endfunction

    // Advance the parser by one character; returns 1 when a number ends
    function automatic bit parse_step(input logic [CHAR_W-1:0] c, output t_result num);
        bit          is_digit;
        logic [31:0] digit;
        logic [31:0] radix;
        num      = '0;
        is_digit = 1'b0;
        digit    = '0;
        if (pr_phase == PH_START) begin
            if (c == CH_MINUS) begin
                pr_negative = 1'b1;
                count_char();
                pr_phase = PH_SIGNED;
                return 1'b0;
            end
            pr_phase = PH_SIGNED;
        end
        if (pr_phase == PH_SIGNED) begin
            if (c == CH_ZERO) begin
                count_char();
                pr_phase = PH_ZERO;
                return 1'b0;
            end
            pr_phase = PH_DIGITS;
        end else if (pr_phase == PH_ZERO) begin
            if (c == CH_UX || c == CH_LX || c == CH_LB) begin
                pr_base = (c == CH_LB) ? BASE_BIN : BASE_HEX;
                count_char();
                pr_phase = PH_DIGITS;
                return 1'b0;
            end
            pr_phase = PH_DIGITS;
        end

        // Digit decode for the current base
        case (pr_base)
            BASE_BIN: begin
                is_digit = (c == CH_ZERO || c == CH_ONE);
                digit    = {16'h0000, c - CH_ZERO};
                radix    = 32'd2;
            end
            BASE_HEX: begin
                radix = 32'd16;
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    is_digit = 1'b1;
                    digit    = {16'h0000, c - CH_ZERO};
                end else if (c >= CH_LA && c <= CH_LF) begin
                    is_digit = 1'b1;
                    digit    = {16'h0000, c - CH_LA} + 32'd10;
                end else if (c >= CH_UA && c <= CH_UF) begin
                    is_digit = 1'b1;
                    digit    = {16'h0000, c - CH_UA} + 32'd10;
                end
            end
            default: begin
                is_digit = (c >= CH_ZERO && c <= CH_NINE);
                digit    = {16'h0000, c - CH_ZERO};
                radix    = 32'd10;
            end
        endcase

        if (is_digit) begin
            pr_acc = pr_acc * radix + digit;
            count_char();
            return 1'b0;
        end

        // Terminator: emit and start over
        num.value      = pr_negative ? (32'd0 - pr_acc) : pr_acc;
        num.chars_used = pr_count;
        num.base_code  = pr_base;
        clear_parser();
        return 1'b1;
    endfunction

    // Table builders
    task automatic add_row(input logic [CHAR_W-1:0] c, input int unsigned reps);
        t_stim_row row;
        row.ch    = c;
        row.reps  = reps;
        row.typed = 1'b0;
        row.res   = '0;
        stim_table.push_back(row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row({8'h00, s[i]}, 1);
    endtask

    task automatic add_checked(input logic [CHAR_W-1:0] c, input logic [31:0] v,
                               input logic [COUNT_W-1:0] n, input t_base b);
        t_stim_row row;
        row.ch               = c;
        row.reps             = 1;
        row.typed            = 1'b1;
        row.res.value        = v;
        row.res.chars_used   = n;
        row.res.base_code    = b;
        stim_table.push_back(row);
    endtask

    // Present one character and wait for its transaction
    task automatic send_char(input logic [CHAR_W-1:0] c, input bit typed,
                             input t_result res);
        if (!calm && $urandom_range(0, 3) == 0) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.character <= c;
        row_typed         <= typed;
        row_res           <= res;
        @(posedge i_clk);
        while (char_if.ready !== 1'b1)
            @(posedge i_clk);
        chars_sent++;
    endtask

    // Result receiver: stalls in bursts until the calm stretch
    always @(posedge i_clk) begin
        if (calm) begin
            res_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left   <= $urandom_range(0, 5);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Prediction on accepted characters, checking of accepted results
    always @(posedge i_clk) begin
        t_result predicted;
        t_result want;
        if (i_rst_n && char_if.valid === 1'b1 && char_if.ready === 1'b1) begin
            if (parse_step(char_if.character, predicted))
                pending_numbers.push_back(row_typed ? row_res : predicted);
        end
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_numbers.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result value=%0d chars_used=%0d base_code=%0d",
                         $time, res_if.value, res_if.chars_used, res_if.base_code);
            end else begin
                want = pending_numbers.pop_front();
                numbers_checked++;
                if (res_if.value !== want.value) begin
                    fault_count++;
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.value, res_if.value);
                end
                if (res_if.chars_used !== want.chars_used) begin
                    fault_count++;
                    $display("%0t: chars_used expected %0d actual %0d",
                             $time, want.chars_used, res_if.chars_used);
                end
                if (res_if.base_code !== want.base_code) begin
                    fault_count++;
                    $display("%0t: base_code expected %0d actual %0d",
                             $time, want.base_code, res_if.base_code);
                end
            end
        end
    end

    // Main sequence
    initial begin
        logic [CHAR_W-1:0] word_q[$];
        t_base             radix_sel;
        int                n_digits;
        int                d;
        int                random_sent;

        char_if.valid     = 1'b0;
        char_if.character = '0;
        res_if.ready      = 1'b0;
        row_typed         = 1'b0;
        row_res           = '0;
        calm              = 1'b0;
        stall_left        = 0;
        chars_sent        = 0;
        numbers_checked   = 0;
        fault_count       = 0;
        clear_parser();

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        add_checked(CH_NUL, 32'd0, 16'd0, BASE_DEC);           // terminator at start
        add_text("-");
        add_checked(CH_NUL, 32'd0, 16'd1, BASE_DEC);           // terminator after sign
        add_text("0x");
        add_checked(CH_UG, 32'd0, 16'd2, BASE_HEX);            // hex prefix, no digits
        add_text("-0b");
        add_checked(CH_TWO, 32'd0, 16'd3, BASE_BIN);           // signed binary prefix only
        add_text("-");
        add_checked(CH_MINUS, 32'd0, 16'd1, BASE_DEC);         // second sign ends it
        add_checked(CH_TOP, 32'd0, 16'd0, BASE_DEC);           // top code as terminator
        add_text("0XFfAa9");
        add_row(CH_NUL, 1);
        add_text("-0b1011");
        add_row(CH_TOP, 1);
        add_text("0xffffffff");
        add_checked(CH_LG, 32'hFFFF_FFFF, 16'd10, BASE_HEX);
        add_text("-99999999999");                              // wraps
        add_row(CH_COMMA, 1);
        add_text("0123");                                      // leading zero is a digit
        add_row(CH_SPACE, 1);
        add_row(CH_SEVEN, LONG_RUN);                           // long run, wraps
        add_row(CH_NUL, 1);

        foreach (stim_table[i])
            for (int unsigned r = 0; r < stim_table[i].reps; r++)
                send_char(stim_table[i].ch, stim_table[i].typed && r == stim_table[i].reps - 1,
                          stim_table[i].res);

        // Random numbers, mostly well formed
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            word_q.delete();
            if ($urandom_range(0, 9) == 0) begin
                word_q.push_back(CHAR_W'($urandom_range(0, 16'hFFFF)));
            end else begin
                if ($urandom_range(0, 2) == 0)
                    word_q.push_back(CH_MINUS);
                case ($urandom_range(0, 4))
                    2: begin
                        radix_sel = BASE_HEX;
                        word_q.push_back(CH_ZERO);
                        word_q.push_back(CH_LX);
                    end
                    3: begin
                        radix_sel = BASE_HEX;
                        word_q.push_back(CH_ZERO);
                        word_q.push_back(CH_UX);
                    end
                    4: begin
                        radix_sel = BASE_BIN;
                        word_q.push_back(CH_ZERO);
                        word_q.push_back(CH_LB);
                    end
                    default: begin
                        radix_sel = BASE_DEC;
                        if ($urandom_range(0, 3) == 0)
                            word_q.push_back(CH_ZERO);
                    end
                endcase
                n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                       : $urandom_range(0, 10);
                for (int k = 0; k < n_digits; k++) begin
                    case (radix_sel)
                        BASE_BIN: word_q.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 1)));
                        BASE_HEX: begin
                            d = $urandom_range(0, 15);
                            if (d < 10)
                                word_q.push_back(CHAR_W'(CH_ZERO + d));
                            else if ($urandom_range(0, 1))
                                word_q.push_back(CHAR_W'(CH_LA + d - 10));
                            else
                                word_q.push_back(CHAR_W'(CH_UA + d - 10));
                        end
                        default: word_q.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
                    endcase
                end
                case ($urandom_range(0, 3))
                    0: word_q.push_back(CH_NUL);
                    1: word_q.push_back(CH_SPACE);
                    2: word_q.push_back(CHAR_W'($urandom_range(0, 16'hFFFF)));
                    default: word_q.push_back(NEAR_DIGITS[$urandom_range(0, 5)]);
                endcase
            end
            foreach (word_q[k]) begin
                if (random_sent >= RANDOM_ITEMS - CALM_ITEMS)
                    calm <= 1'b1;
                send_char(word_q[k], 1'b0, '0);
                random_sent++;
            end
        end
        // Flush whatever number is still open
        send_char(CH_NUL, 1'b0, '0);
        char_if.valid <= 1'b0;

        while (pending_numbers.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d characters (directed table, %0d-digit run, random numbers)",
                 chars_sent, LONG_RUN);
        $display("Checked %0d parsed numbers in decimal, hex and binary", numbers_checked);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #1_200_000;
        $display("Timeout with %0d results outstanding", pending_numbers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/ttiba_pkg.sv
hdl/ttiba_char_if.sv
hdl/ttiba_res_if.sv
hdl/ttiba_in_stage.sv
hdl/ttiba_parser.sv
hdl/ttiba_out_stage.sv
hdl/text_to_int_base_autodetect_top.sv
verif/testbench.sv
